[rtl/wss_pkg.sv]
// Shared types, codes and the week-time helper for the weekly schedule switch.
`timescale 1ns / 1ps

package wss_pkg;

   // Default table sizes
   localparam int POINTS_PER_CHANNEL_DEF = 16;
   localparam int HOLIDAY_SLOTS_DEF      = 16;
   localparam int NUM_CHANNELS           = 4;

   // Field and port widths
   localparam int POINT_W    = 14;
   localparam int DATE_W     = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 5;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;

   typedef logic [POINT_W-1:0] point_type;
   typedef logic [DATE_W-1:0]  date_type;

   // Command codes carried in req_tuser
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_POINT   = 2'd1;
   localparam logic [1:0] CMD_HOLIDAY = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_HOUR_OFFSET   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HOLIDAY_COUNT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_HEATING_COUNT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_FLOOR_COUNT   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_CIRC_COUNT    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SHOWER_COUNT  = 3'd5;

   // Minutes since Sunday midnight; all inputs in range keep it below 2^14
   function automatic point_type week_time(input logic [2:0] wday,
                                           input logic [5:0] hour,
                                           input logic [5:0] minute);
      week_time = POINT_W'(wday) * POINT_W'(1440)
                + POINT_W'(hour) * POINT_W'(60)
                + POINT_W'(minute);
   endfunction

endpackage

[rtl/wss_point_store.sv]
// On and off switch point memories for all channels, one shared read port.
`timescale 1ns / 1ps

module wss_point_store #(
   parameter int DEPTH = 4 * wss_pkg::POINTS_PER_CHANNEL_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic               wr_off,
   input  logic [AW-1:0]      wr_addr,
   input  wss_pkg::point_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output wss_pkg::point_type rd_on,
   output wss_pkg::point_type rd_off
);
   import wss_pkg::*;

   point_type on_mem  [DEPTH];
   point_type off_mem [DEPTH];
   point_type rd_on_ff;
   point_type rd_off_ff;

   // Write one kind of point, read both kinds of a pair
   always_ff @(posedge clock) begin
      if (wr_en && !wr_off) begin
         on_mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_off) begin
         off_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_on_ff  <= on_mem[rd_addr];
         rd_off_ff <= off_mem[rd_addr];
      end
   end

   assign rd_on  = rd_on_ff;
   assign rd_off = rd_off_ff;

endmodule

[rtl/weekly_schedule_switch.sv]
// Top level of the weekly schedule switch: command decode, sequencer, holiday table.
`timescale 1ns / 1ps

// Usage:
// - req_* takes one command beat per accept: a clock tick, a switch point write
//   or a holiday write, selected by req_tuser. Writes complete in the accept
//   cycle and give no result; unknown commands are dropped.
// - A tick gives exactly one rsp_* beat with the four channel states and the
//   second, minute and hour change flags.
// - csr_* sets hour offset, holiday count, four point counts; user must write while idle; unchecked.
// - A tick scans the holidays, then each channel's points in turn. The holiday
//   memory and the point memories each read one entry per cycle; the channel
//   scan stops at the first off point found.
// - req_tready is high only while idle, so one tick is in flight at a time.
// - A stalled result holds on rsp_tdata until rsp_tready; no beat is taken then.
// - Reset clears the sequencer, the previous-time registers and the config
//   registers (hour offset 1, counts 0). Table contents are undefined until
//   written.

module weekly_schedule_switch #(
   parameter int POINTS_PER_CHANNEL = wss_pkg::POINTS_PER_CHANNEL_DEF,
   parameter int HOLIDAY_SLOTS      = wss_pkg::HOLIDAY_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // weekday[2:0] hour[7:3] minute[13:8] second[19:14] month[23:20] day[28:24]
   // channel[30:29] edge_kind[31] entry_index[35:32], zero fill[39:36]
   input  logic [wss_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[1:0]
   input  logic [wss_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // heating_normal[0] floor_normal[1] circulation_on[2] shower_active[3]
   // second_changed[4] minute_changed[5] hour_changed[6], zero fill[7]
   output logic [wss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [wss_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [wss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wss_pkg::*;

   localparam int P     = POINTS_PER_CHANNEL;
   localparam int H     = HOLIDAY_SLOTS;
   localparam int DEPTH = NUM_CHANNELS * P;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(P + 1);
   localparam int PA    = (P > 1) ? $clog2(P) : 1;
   localparam int HW    = $clog2(H + 1);
   localparam int HA    = (H > 1) ? $clog2(H) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HOL  = 3'd1;
   localparam logic [2:0] ST_TIME = 3'd2;
   localparam logic [2:0] ST_CHAN = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // Request fields
   logic [1:0] req_command;
   logic [2:0] req_weekday;
   logic [4:0] req_hour;
   logic [5:0] req_minute;
   logic [5:0] req_second;
   logic [3:0] req_month;
   logic [4:0] req_day;
   logic [1:0] req_channel;
   logic       req_edge_kind;
   logic [3:0] req_entry_index;

   assign req_command     = req_tuser[1:0];
   assign req_weekday     = req_tdata[2:0];
   assign req_hour        = req_tdata[7:3];
   assign req_minute      = req_tdata[13:8];
   assign req_second      = req_tdata[19:14];
   assign req_month       = req_tdata[23:20];
   assign req_day         = req_tdata[28:24];
   assign req_channel     = req_tdata[30:29];
   assign req_edge_kind   = req_tdata[31];
   assign req_entry_index = req_tdata[35:32];

   // Config registers
   logic [4:0] offset_hours_ff;
   logic [4:0] holiday_count_ff;
   logic [4:0] chan_count_ff [NUM_CHANNELS];

   // Sequencer state
   logic [2:0]    state_ff,     state_in;
   logic [HW-1:0] hol_idx_ff,   hol_idx_in;
   logic          hol_vld_ff,   hol_vld_in;
   logic          hit_ff,       hit_in;
   logic [1:0]    chan_ff,      chan_in;
   logic [PW-1:0] pt_ff,        pt_in;
   logic          prd_vld_ff,   prd_vld_in;
   logic          found_ff,     found_in;
   logic [3:0]    act_ff,       act_in;
   point_type     wt_ff,        wt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Tick payload and previous time
   logic [2:0] wday_ff;
   logic [5:0] ohour_ff;
   logic [5:0] minute_ff;
   date_type   date_ff;
   logic [2:0] chg_ff;
   logic [5:0] last_sec_ff;
   logic [5:0] last_min_ff;
   logic [5:0] last_hour_ff;

   // Holiday memory
   date_type hol_mem [H];
   date_type hol_rdata_ff;

   logic          req_fire;
   logic          tick_fire;
   logic [5:0]    req_ohour;
   logic [HW-1:0] hol_n;
   logic [PW-1:0] pt_n;
   logic          hol_issue;
   logic          pt_issue;
   logic [AW-1:0] pt_rd_addr;
   logic          pt_we;
   logic [AW-1:0] pt_wr_addr;
   logic          hol_we;
   point_type     pt_on;
   point_type     pt_off;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign tick_fire  = req_fire && (req_command == CMD_TICK);
   assign req_ohour  = 6'(req_hour) + 6'(offset_hours_ff);

   // Clamp counts to the table sizes
   assign hol_n = (32'(holiday_count_ff) > 32'(H)) ? HW'(H) : HW'(holiday_count_ff);
   assign pt_n  = (32'(chan_count_ff[chan_ff]) > 32'(P)) ? PW'(P)
                                                         : PW'(chan_count_ff[chan_ff]);

   assign hol_issue  = (state_ff == ST_HOL) && (hol_idx_ff < hol_n);
   assign pt_issue   = (state_ff == ST_CHAN) && !found_ff && (pt_ff < pt_n);
   assign pt_rd_addr = AW'(chan_ff) * AW'(P) + AW'(pt_ff[PA-1:0]);

   // Table writes
   assign pt_we      = req_fire && (req_command == CMD_POINT)
                       && (32'(req_entry_index) < 32'(P));
   assign pt_wr_addr = AW'(req_channel) * AW'(P) + AW'(req_entry_index);
   assign hol_we     = req_fire && (req_command == CMD_HOLIDAY)
                       && (32'(req_entry_index) < 32'(H));

   wss_point_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_point_store (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_off  (req_edge_kind),
      .wr_addr (pt_wr_addr),
      .wr_data (week_time(req_weekday, 6'(req_hour), req_minute)),
      .rd_en   (pt_issue),
      .rd_addr (pt_rd_addr),
      .rd_on   (pt_on),
      .rd_off  (pt_off)
   );

   // Holiday memory: write on command, read one slot per cycle during the scan
   always_ff @(posedge clock) begin
      if (hol_we) begin
         hol_mem[HA'(req_entry_index)] <= {req_month, req_day};
      end
      if (hol_issue) begin
         hol_rdata_ff <= hol_mem[hol_idx_ff[HA-1:0]];
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      hol_idx_in   = hol_idx_ff;
      hol_vld_in   = hol_vld_ff;
      hit_in       = hit_ff;
      chan_in      = chan_ff;
      pt_in        = pt_ff;
      prd_vld_in   = prd_vld_ff;
      found_in     = found_ff;
      act_in       = act_ff;
      wt_in        = wt_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_fire) begin
               state_in   = ST_HOL;
               hol_idx_in = '0;
               hol_vld_in = 1'b0;
               hit_in     = 1'b0;
            end
         end
         ST_HOL: begin
            // Issue the next slot, compare the one read last cycle
            hol_vld_in = hol_issue;
            if (hol_issue) begin
               hol_idx_in = hol_idx_ff + HW'(1);
            end
            if (hol_vld_ff && (hol_rdata_ff == date_ff)) begin
               hit_in = 1'b1;
            end
            if (!hol_issue && !hol_vld_ff) begin
               state_in = ST_TIME;
            end
         end
         ST_TIME: begin
            // A holiday counts as Sunday
            wt_in      = week_time(hit_ff ? 3'd0 : wday_ff, ohour_ff, minute_ff);
            chan_in    = 2'd0;
            pt_in      = '0;
            prd_vld_in = 1'b0;
            found_in   = 1'b0;
            act_in     = 4'd0;
            state_in   = ST_CHAN;
         end
         ST_CHAN: begin
            // Issue the next pair, compare the pair read last cycle
            prd_vld_in = pt_issue;
            if (pt_issue) begin
               pt_in = pt_ff + PW'(1);
            end
            if (prd_vld_ff && !found_ff && (wt_ff <= pt_off)) begin
               found_in        = 1'b1;
               act_in[chan_ff] = (wt_ff > pt_on);
            end
            // Advance to the next channel, or to the output after the last, once nothing is in flight
            if (!pt_issue && !prd_vld_ff) begin
               if (chan_ff == 2'd3) begin
                  state_in     = ST_OUT;
                  rsp_valid_in = 1'b1;
               end else begin
                  chan_in  = chan_ff + 2'd1;
                  pt_in    = '0;
                  found_in = 1'b0;
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hol_idx_ff   <= '0;
         hol_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         chan_ff      <= 2'd0;
         pt_ff        <= '0;
         prd_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_sec_ff  <= 6'd0;
         last_min_ff  <= 6'd0;
         last_hour_ff <= 6'd0;
      end else begin
         state_ff     <= state_in;
         hol_idx_ff   <= hol_idx_in;
         hol_vld_ff   <= hol_vld_in;
         hit_ff       <= hit_in;
         chan_ff      <= chan_in;
         pt_ff        <= pt_in;
         prd_vld_ff   <= prd_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tick_fire) begin
            last_sec_ff  <= req_second;
            last_min_ff  <= req_minute;
            last_hour_ff <= req_ohour;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff <= act_in;
      wt_ff  <= wt_in;
      if (tick_fire) begin
         wday_ff   <= req_weekday;
         ohour_ff  <= req_ohour;
         minute_ff <= req_minute;
         date_ff   <= {req_month, req_day};
         chg_ff    <= {req_ohour != last_hour_ff,
                       req_minute != last_min_ff,
                       req_second != last_sec_ff};
      end
   end

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_hours_ff  <= 5'd1;
         holiday_count_ff <= 5'd0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_count_ff[i] <= 5'd0;
         end
      end else if (csr_we) begin
         case (csr_addr)
            REG_HOUR_OFFSET:   offset_hours_ff  <= csr_wdata;
            REG_HOLIDAY_COUNT: holiday_count_ff <= csr_wdata;
            REG_HEATING_COUNT: chan_count_ff[0] <= csr_wdata;
            REG_FLOOR_COUNT:   chan_count_ff[1] <= csr_wdata;
            REG_CIRC_COUNT:    chan_count_ff[2] <= csr_wdata;
            REG_SHOWER_COUNT:  chan_count_ff[3] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, chg_ff, act_ff};

endmodule
